FILE: design/alt_pkg.sv
// Argument line tokenizer package: result kinds, byte codes and the result record.
// Used by the output interface, the top level and the checker.
`timescale 1ns / 1ps

package alt_pkg;

	localparam int unsigned MaxResults = 3;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_FINAL = 2'd2
	} kind_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
	} res_t;

endpackage

FILE: design/alt_in_if.sv
// Input channel of the argument line tokenizer: one line byte per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface alt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       line_end;

	modport source (output valid, output ch, output line_end, input ready);
	modport sink (input valid, input ch, input line_end, output ready);
endinterface

FILE: design/alt_out_if.sv
// Output channel of the argument line tokenizer: one argument byte or end mark per request.
// Depends on alt_pkg.
`timescale 1ns / 1ps

interface alt_out_if
	import alt_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	kind_t      kind;
	logic       run_last;

	modport source (output valid, output out_byte, output kind, output run_last, input ready);
	modport sink (input valid, input out_byte, input kind, input run_last, output ready);
endinterface

FILE: design/argument_line_tokenizer.sv
// Argument line tokenizer top level: quote/escape flags, result decode and result buffer.
// Depends on alt_pkg, alt_in_if and alt_out_if.
`timescale 1ns / 1ps

// One line byte is taken per request on item; it yields zero to three results on result,
// issued one per cycle while result.ready holds, from a three-entry result buffer, the last
// of them flagged run_last. A byte yielding at most one result is taken every cycle while
// result.ready holds: the next byte is accepted in the same cycle as the previous byte's
// last result leaves. A byte yielding more holds item until its last result leaves. A byte
// with line_end set ends with a final-argument mark and resets the quote and escape flags.
module argument_line_tokenizer
	import alt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	alt_in_if.sink      item,
	alt_out_if.source   result
);

	logic in_argument_q, escape_pending_q, in_double_quote_q, in_single_quote_q;
	res_t       res_s1 [MaxResults];
	logic [1:0] cnt_s1;
	logic [1:0] idx_q;

	logic       out_valid, last_slot, in_acc, out_acc;
	logic       blank, pre_bs, main_en;
	logic [7:0] main_byte;
	kind_t      main_kind;
	logic       arg_d, esc_d, dq_d, sq_d;
	res_t       slots [MaxResults];
	logic [1:0] n;

	assign out_valid  = (cnt_s1 != idx_q);
	assign last_slot  = (idx_q + 2'd1 == cnt_s1);
	assign item.ready = !out_valid || (last_slot && result.ready);
	assign in_acc     = item.valid && item.ready;
	assign out_acc    = out_valid && result.ready;

	assign result.valid    = out_valid;
	assign result.out_byte = res_s1[idx_q].out_byte;
	assign result.kind     = res_s1[idx_q].kind;
	assign result.run_last = last_slot;

	assign blank = (item.ch == CH_SPACE) || (item.ch == CH_TAB);

	always_comb begin
		arg_d     = in_argument_q;
		esc_d     = escape_pending_q;
		dq_d      = in_double_quote_q;
		sq_d      = in_single_quote_q;
		pre_bs    = 1'b0;
		main_en   = 1'b0;
		main_byte = item.ch;
		main_kind = KIND_BYTE;
		if (blank) begin
			if (escape_pending_q || in_double_quote_q || in_single_quote_q) begin
				main_en = 1'b1;
			end else if (in_argument_q) begin
				main_en   = 1'b1;
				main_byte = 8'h00;
				main_kind = KIND_END;
				arg_d     = 1'b0;
			end
		end else begin
			arg_d = 1'b1;
			case (item.ch)
				CH_BSLASH: begin
					main_en = escape_pending_q;
					esc_d   = !escape_pending_q;
				end
				CH_DQUOTE: begin
					if (escape_pending_q) begin
						esc_d   = 1'b0;
						pre_bs  = in_single_quote_q;
						main_en = 1'b1;
					end else if (in_single_quote_q) begin
						main_en = 1'b1;
					end else begin
						dq_d = !in_double_quote_q;
					end
				end
				CH_SQUOTE: begin
					if (escape_pending_q) begin
						esc_d   = 1'b0;
						pre_bs  = in_double_quote_q;
						main_en = 1'b1;
					end else if (in_double_quote_q) begin
						main_en = 1'b1;
					end else begin
						sq_d = !in_single_quote_q;
					end
				end
				default: begin
					main_en = 1'b1;
					if (escape_pending_q) begin
						esc_d  = 1'b0;
						pre_bs = in_double_quote_q || in_single_quote_q;
					end
				end
			endcase
		end
		if (item.line_end) begin
			arg_d = 1'b0;
			esc_d = 1'b0;
			dq_d  = 1'b0;
			sq_d  = 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < MaxResults; i++) begin
			slots[i] = '{out_byte: 8'h00, kind: KIND_BYTE};
		end
		n = 2'd0;
		if (pre_bs) begin
			slots[n] = '{out_byte: CH_BSLASH, kind: KIND_BYTE};
			n = n + 2'd1;
		end
		if (main_en) begin
			slots[n] = '{out_byte: main_byte, kind: main_kind};
			n = n + 2'd1;
		end
		if (item.line_end) begin
			slots[n] = '{out_byte: 8'h00, kind: KIND_FINAL};
			n = n + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_argument_q     <= 1'b0;
			escape_pending_q  <= 1'b0;
			in_double_quote_q <= 1'b0;
			in_single_quote_q <= 1'b0;
			cnt_s1            <= 2'd0;
			idx_q             <= 2'd0;
		end else if (in_acc) begin
			in_argument_q     <= arg_d;
			escape_pending_q  <= esc_d;
			in_double_quote_q <= dq_d;
			in_single_quote_q <= sq_d;
			cnt_s1            <= n;
			idx_q             <= 2'd0;
		end else if (out_acc) begin
			if (last_slot) begin
				cnt_s1 <= 2'd0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < MaxResults; i++) begin
				res_s1[i] <= slots[i];
			end
		end
	end

endmodule

FILE: design/alt_checker.sv
// Port-level checks for the argument line tokenizer, bound to the top level.
// Depends on alt_pkg.
`timescale 1ns / 1ps

module alt_checker
	import alt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input kind_t      kind,
	input logic       run_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(run_last))
		else $error("result changed while stalled");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FINAL |-> run_last)
		else $error("final mark not last of its request");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BYTE |-> out_byte == 8'h00)
		else $error("end mark carries a byte");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_END && !run_last |=> out_valid
			&& kind == KIND_FINAL)
		else $error("end mark followed by something other than final mark");

endmodule

bind argument_line_tokenizer alt_checker u_alt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_byte  (result.out_byte),
	.kind      (result.kind),
	.run_last  (result.run_last)
);
